FILE: design/utp_pkg.sv
// Shared types, codes and constants for the timepulse configuration sequencer.
// Holds the CFG-TP5 frame table and the controller/datapath interface structs.
// No dependencies.
package utp_pkg;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_RXBYTE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_OUTCOME = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;

  localparam logic [1:0] OC_ACK     = 2'd0;
  localparam logic [1:0] OC_NAK     = 2'd1;
  localparam logic [1:0] OC_FAIL    = 2'd2;
  localparam logic [1:0] OC_TIMEOUT = 2'd3;

  localparam logic [1:0] REG_FREQ    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_NEEDED  = 2'd2;
  localparam logic [1:0] REG_MAXATT  = 2'd3;

  localparam logic [31:0] FREQ_RST    = 32'd100000;
  localparam logic [15:0] TIMEOUT_RST = 16'd1500;
  localparam logic [3:0]  NEEDED_RST  = 4'd3;
  localparam logic [3:0]  MAXATT_RST  = 4'd10;

  localparam logic [7:0] SYNC1     = 8'hB5;
  localparam logic [7:0] SYNC2     = 8'h62;
  localparam logic [7:0] ACK_CLASS = 8'h05;
  localparam logic [7:0] CFG_CLASS = 8'h06;
  localparam logic [7:0] TP5_ID    = 8'h31;

  localparam logic [5:0] IDX_CK_FIRST = 6'd2;
  localparam logic [5:0] IDX_CK_LAST  = 6'd37;
  localparam logic [5:0] IDX_CK_A     = 6'd38;
  localparam logic [5:0] IDX_CK_B     = 6'd39;

  localparam logic [3:0] POS_NAK    = 4'd3;
  localparam logic [3:0] POS_SUMEND = 4'd7;
  localparam logic [3:0] POS_CLASS  = 4'd6;
  localparam logic [3:0] POS_ID     = 4'd7;
  localparam logic [3:0] POS_CK_A   = 4'd8;
  localparam logic [3:0] POS_CK_B   = 4'd9;

  typedef struct packed {
    logic accept;
    logic ld_outcome;
    logic start_send;
    logic ld_byte;
    logic ld_final;
  } utp_cmd_t;

  typedef struct packed {
    logic start;
    logic evt;
    logic done;
    logic last_byte;
    logic out_free;
  } utp_stat_t;

  function automatic logic [7:0] frame_byte(input logic [5:0] idx, input logic [31:0] freq);
    logic [7:0] b;
    unique case (idx) inside
      6'd0:         b = SYNC1;
      6'd1:         b = SYNC2;
      6'd2:         b = CFG_CLASS;
      6'd3:         b = TP5_ID;
      6'd4:         b = 8'h20;
      6'd7:         b = 8'h01;
      6'd10:        b = 8'h32;
      6'd14, 6'd18: b = freq[7:0];
      6'd15, 6'd19: b = freq[15:8];
      6'd16, 6'd20: b = freq[23:16];
      6'd17, 6'd21: b = freq[31:24];
      6'd25, 6'd29: b = 8'h80;
      6'd34:        b = 8'hEF;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/utp_dp.sv
// Datapath: configuration registers, reply parser, timeout counter, attempt
// counters, frame byte generator with Fletcher-8 and the output register.
// Depends on utp_pkg.
module utp_dp import utp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  utp_cmd_t    cmd,
  output utp_stat_t   st,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic [31:0] freq_r;
  logic [15:0] timeout_r;
  logic [3:0]  needed_r, maxatt_r;
  logic [3:0]  ack_r, att_r;
  logic        wait_r;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  ra_r, ra_nxt, rb_r, rb_nxt;
  logic [7:0]  b6_r, b7_r, b8_r;
  logic [15:0] ticks_r, ticks_nxt;
  logic [1:0]  oc_r, oc_nxt;
  logic        evt;
  logic [5:0]  idx_r;
  logic [7:0]  fa_r, fb_r, fa_nxt, fb_nxt;
  logic [7:0]  tx_nxt, exp_byte, ra_add, rb_add;
  logic        out_valid_r, out_last_r, out_fin_r;
  logic [1:0]  out_kind_r, out_oc_r;
  logic [7:0]  out_tx_r;
  logic        load;

  always_comb begin
    unique case (pos_r[1:0])
      2'd0:    exp_byte = SYNC1;
      2'd1:    exp_byte = SYNC2;
      default: exp_byte = ACK_CLASS;
    endcase
    ra_add    = ra_r + in_tdata;
    rb_add    = rb_r + ra_add;
    pos_nxt   = pos_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    ticks_nxt = ticks_r;
    evt       = 1'b0;
    oc_nxt    = OC_ACK;
    if (wait_r && in_tuser == CMD_RXBYTE) begin
      if (pos_r < POS_NAK) begin
        if (in_tdata == exp_byte) pos_nxt = pos_r + 4'd1;
      end else begin
        pos_nxt = pos_r + 4'd1;
        if (pos_r <= POS_SUMEND) begin
          ra_nxt = ra_add;
          rb_nxt = rb_add;
        end
        if (pos_r == POS_NAK && in_tdata == 8'h00) begin
          evt    = 1'b1;
          oc_nxt = OC_NAK;
        end
        if (pos_r == POS_CK_B) begin
          evt    = 1'b1;
          oc_nxt = (b6_r == CFG_CLASS && b7_r == TP5_ID && ra_r == b8_r && rb_r == in_tdata)
                   ? OC_ACK : OC_FAIL;
        end
      end
    end else if (wait_r && in_tuser == CMD_TICK) begin
      if (ticks_r >= timeout_r) begin
        evt    = 1'b1;
        oc_nxt = OC_TIMEOUT;
      end else begin
        ticks_nxt = ticks_r + 16'd1;
      end
    end
  end

  always_comb begin
    case (idx_r)
      IDX_CK_A: tx_nxt = fa_r;
      IDX_CK_B: tx_nxt = fb_r;
      default:  tx_nxt = frame_byte(idx_r, freq_r);
    endcase
    fa_nxt = fa_r + tx_nxt;
    fb_nxt = fb_r + fa_nxt;
  end

  assign st.start     = (in_tuser == CMD_START);
  assign st.evt       = evt;
  assign st.done      = (ack_r >= needed_r) || (att_r >= maxatt_r);
  assign st.last_byte = (idx_r == IDX_CK_B);
  assign st.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r    <= FREQ_RST;
      timeout_r <= TIMEOUT_RST;
      needed_r  <= NEEDED_RST;
      maxatt_r  <= MAXATT_RST;
      ack_r     <= 4'd0;
      att_r     <= 4'd0;
      wait_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FREQ:    freq_r    <= cfg_data;
          REG_TIMEOUT: timeout_r <= cfg_data[15:0];
          REG_NEEDED:  needed_r  <= cfg_data[3:0];
          REG_MAXATT:  maxatt_r  <= cfg_data[3:0];
          default:     ;
        endcase
      end
      if (cmd.accept && st.start) begin
        ack_r <= 4'd0;
        att_r <= 4'd0;
      end else if (cmd.accept && evt && oc_nxt == OC_ACK) begin
        ack_r <= ack_r + 4'd1;
      end
      if (cmd.start_send) begin
        att_r  <= att_r + 4'd1;
        wait_r <= 1'b1;
      end
      if (cmd.ld_final) wait_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_r   <= pos_nxt;
      ra_r    <= ra_nxt;
      rb_r    <= rb_nxt;
      ticks_r <= ticks_nxt;
      oc_r    <= oc_nxt;
      if (wait_r && in_tuser == CMD_RXBYTE) begin
        if (pos_r == POS_CLASS) b6_r <= in_tdata;
        if (pos_r == POS_ID)    b7_r <= in_tdata;
        if (pos_r == POS_CK_A)  b8_r <= in_tdata;
      end
    end
    if (cmd.start_send) begin
      pos_r   <= 4'd0;
      ra_r    <= ACK_CLASS;
      rb_r    <= ACK_CLASS;
      ticks_r <= 16'd0;
      idx_r   <= 6'd0;
      fa_r    <= 8'd0;
      fb_r    <= 8'd0;
    end
    if (cmd.ld_byte) begin
      idx_r <= idx_r + 6'd1;
      if (idx_r >= IDX_CK_FIRST && idx_r <= IDX_CK_LAST) begin
        fa_r <= fa_nxt;
        fb_r <= fb_nxt;
      end
    end
  end

  assign load = cmd.ld_outcome || cmd.ld_byte || cmd.ld_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_outcome) begin
      out_kind_r <= KIND_OUTCOME;
      out_tx_r   <= 8'd0;
      out_oc_r   <= oc_r;
      out_fin_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (cmd.ld_byte) begin
      out_kind_r <= KIND_TX;
      out_tx_r   <= tx_nxt;
      out_oc_r   <= OC_ACK;
      out_fin_r  <= 1'b0;
      out_last_r <= (idx_r == IDX_CK_B);
    end else if (cmd.ld_final) begin
      out_kind_r <= KIND_FINAL;
      out_tx_r   <= 8'd0;
      out_oc_r   <= OC_ACK;
      out_fin_r  <= (ack_r >= needed_r);
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_fin_r, out_oc_r, out_tx_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: design/utp_ctrl.sv
// Controller: sequences input acceptance, outcome report, send decision,
// frame emission and final status. Depends on utp_pkg.
module utp_ctrl import utp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  utp_stat_t st,
  output utp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_OUTCOME, S_DECIDE, S_SEND, S_FINAL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          if (st.start)    state_nxt = S_DECIDE;
          else if (st.evt) state_nxt = S_OUTCOME;
        end
      end
      S_OUTCOME: begin
        if (st.out_free) begin
          cmd.ld_outcome = 1'b1;
          state_nxt      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.done) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.start_send = 1'b1;
          state_nxt      = S_SEND;
        end
      end
      S_SEND: begin
        if (st.out_free) begin
          cmd.ld_byte = 1'b1;
          if (st.last_byte) state_nxt = S_IDLE;
        end
      end
      S_FINAL: begin
        if (st.out_free) begin
          cmd.ld_final = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

FILE: design/ubx_timepulse_config_with_ack.sv
// Timepulse configuration sequencer: sends a 40-byte CFG-TP5 frame with a
// Fletcher-8 checksum, parses the ACK/NAK reply and retries until enough
// acknowledges or the attempt limit. Bytes and ticks that cause no result
// leave the sequencer ready for the next item. An item that ends an attempt
// is accepted, then the outcome is reported, the send decision is made, and
// then the frame is emitted byte by byte (40 bytes) or the final status is
// loaded; a start skips the outcome step. Frame emission is byte-serial
// through the single output register, and each result waits while out_tready
// is low. Input is held off while an outcome, frame or status is being
// emitted. The config port is always ready. Depends on utp_pkg, utp_ctrl and
// utp_dp.
module ubx_timepulse_config_with_ack import utp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] tx_byte, [9:8] outcome, [10] final_ok
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  utp_cmd_t  cmd;
  utp_stat_t st;

  assign cfg_ready = 1'b1;

  utp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  utp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: test/tb_ubx_timepulse_config_with_ack.sv
`timescale 1ns / 100ps
// Testbench for the timepulse configuration sequencer: drives start, reply-byte and tick
// transfers, predicts every frame byte, attempt outcome and final status, and checks them.
// Depends on utp_pkg and ubx_timepulse_config_with_ack.
module tb_ubx_timepulse_config_with_ack;
  import utp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] TP5_LEN = 8'h20;
  localparam logic [7:0] TP5_VERSION = 8'h01;
  localparam logic [7:0] CABLE_DELAY = 8'h32;
  localparam logic [7:0] DUTY_HALF = 8'h80;
  localparam logic [7:0] TP5_FLAGS = 8'hEF;
  localparam logic [7:0] ACK_ID = 8'h01;
  localparam logic [7:0] NAK_ID = 8'h00;
  localparam logic [7:0] ACK_LEN = 8'h02;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 20000;

  typedef enum {RPL_ACK, RPL_NAK, RPL_BAD} reply_kind_t;
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx;
  } rx_item_t;
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx;
    logic [1:0] oc;
    logic       fin;
    logic       last;
  } seq_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the registers and the sequencer state
  logic [31:0] hz_cfg = FREQ_RST;
  logic [15:0] tmo_cfg = TIMEOUT_RST;
  logic [3:0]  need_cfg = NEEDED_RST;
  logic [3:0]  maxatt_cfg = MAXATT_RST;
  logic        awaiting_reply;
  logic [3:0]  reply_pos;
  logic [7:0]  reply_buf [10];
  logic [15:0] tick_count;
  logic [3:0]  ack_tally;
  logic [3:0]  send_tally;
  logic [7:0]  tp5_frame [40];

  seq_beat_t step_beats [$];
  seq_beat_t frame_status_q [$];
  rx_item_t  drive_q [$];

  int items_sent = 0;
  int items_accepted = 0;
  int live_items = 0;
  int results_seen = 0;
  int mismatches = 0;
  int outcome_tally [4];
  int finals_ok = 0;
  int finals_failed = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  ubx_timepulse_config_with_ack dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] reply_sum(input logic [47:0] body);
    logic [7:0] a;
    logic [7:0] b;
    int i;
    a = '0;
    b = '0;
    for (i = 0; i < 6; i++) begin
      a = a + body[8*i +: 8];
      b = b + a;
    end
    return {b, a};
  endfunction

  task automatic clear_reply;
    int i;
    for (i = 0; i < 10; i++) reply_buf[i] = 8'h00;
    reply_buf[0] = SYNC1;
    reply_buf[1] = SYNC2;
    reply_buf[2] = ACK_CLASS;
    reply_pos = '0;
    tick_count = '0;
  endtask

  task automatic reset_sequencer;
    clear_reply;
    awaiting_reply = 1'b0;
    ack_tally = '0;
    send_tally = '0;
  endtask

  task automatic add_beat(input logic [1:0] kind, input logic [7:0] tx, input logic [1:0] oc,
                          input logic fin);
    seq_beat_t b;
    b.kind = kind;
    b.tx = tx;
    b.oc = oc;
    b.fin = fin;
    b.last = 1'b0;
    step_beats.push_back(b);
  endtask

  // finish the sequence or send the CFG-TP5 frame again
  task automatic next_send;
    logic [7:0] a;
    logic [7:0] b;
    int i;
    if (ack_tally >= need_cfg || send_tally >= maxatt_cfg) begin
      add_beat(KIND_FINAL, '0, '0, ack_tally >= need_cfg);
      if (ack_tally >= need_cfg) finals_ok++;
      else finals_failed++;
      awaiting_reply = 1'b0;
    end else begin
      for (i = 0; i < 40; i++) tp5_frame[i] = 8'h00;
      tp5_frame[0] = SYNC1;
      tp5_frame[1] = SYNC2;
      tp5_frame[2] = CFG_CLASS;
      tp5_frame[3] = TP5_ID;
      tp5_frame[4] = TP5_LEN;
      tp5_frame[7] = TP5_VERSION;
      tp5_frame[10] = CABLE_DELAY;
      for (i = 0; i < 4; i++) begin
        tp5_frame[14 + i] = hz_cfg[8*i +: 8];
        tp5_frame[18 + i] = hz_cfg[8*i +: 8];
      end
      tp5_frame[25] = DUTY_HALF;
      tp5_frame[29] = DUTY_HALF;
      tp5_frame[34] = TP5_FLAGS;
      a = '0;
      b = '0;
      for (i = 2; i < 38; i++) begin
        a = a + tp5_frame[i];
        b = b + a;
      end
      tp5_frame[38] = a;
      tp5_frame[39] = b;
      send_tally = send_tally + 4'd1;
      for (i = 0; i < 40; i++) add_beat(KIND_TX, tp5_frame[i], '0, 1'b0);
      clear_reply;
      awaiting_reply = 1'b1;
    end
  endtask

  task automatic close_attempt(input logic [1:0] oc);
    if (oc == OC_ACK) ack_tally = ack_tally + 4'd1;
    outcome_tally[oc]++;
    add_beat(KIND_OUTCOME, '0, oc, 1'b0);
    next_send;
  endtask

  task automatic run_sequencer(input logic [1:0] cmd, input logic [7:0] rx);
    int p;
    logic [15:0] sum;
    seq_beat_t b;
    step_beats.delete();
    case (cmd)
      CMD_START: begin
        ack_tally = '0;
        send_tally = '0;
        awaiting_reply = 1'b0;
        next_send;
      end
      CMD_RXBYTE: if (awaiting_reply) begin
        p = reply_pos;
        if (p < 10) begin
          if (rx == reply_buf[p]) begin
            p++;
          end else if (p > 2) begin
            reply_buf[p] = rx;
            p++;
          end
        end
        reply_pos = p[3:0];
        if (p > 9) begin
          sum = reply_sum({reply_buf[7], reply_buf[6], reply_buf[5], reply_buf[4],
                           reply_buf[3], reply_buf[2]});
          if (reply_buf[6] == CFG_CLASS && reply_buf[7] == TP5_ID &&
              sum == {reply_buf[9], reply_buf[8]})
            close_attempt(OC_ACK);
          else
            close_attempt(OC_FAIL);
        end else if (p == 4 && reply_buf[3] == NAK_ID) begin
          close_attempt(OC_NAK);
        end
      end
      CMD_TICK: if (awaiting_reply) begin
        if (tick_count >= tmo_cfg) close_attempt(OC_TIMEOUT);
        else tick_count = tick_count + 16'd1;
      end
      default: ;
    endcase
    if (step_beats.size() > 0) begin
      b = step_beats[$];
      b.last = 1'b1;
      step_beats[step_beats.size() - 1] = b;
    end
    foreach (step_beats[i]) frame_status_q.push_back(step_beats[i]);
  endtask

  // predict on every input transfer, check every result transfer
  always @(posedge clk) begin : monitor
    seq_beat_t want;
    if (!rst_n) begin
      reset_sequencer;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_START ||
            (awaiting_reply && (in_tuser == CMD_RXBYTE || in_tuser == CMD_TICK)))
          live_items++;
        items_accepted++;
        run_sequencer(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (frame_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result kind %0d data %h last %b",
                     out_tuser, out_tdata, out_tlast);
        end else begin
          want = frame_status_q.pop_front();
          if (out_tuser !== want.kind || out_tdata !== {5'b0, want.fin, want.oc, want.tx} ||
              out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected kind %0d data %h last %b, got %0d %h %b",
                       results_seen, want.kind, {5'b0, want.fin, want.oc, want.tx}, want.last,
                       out_tuser, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // advance to the next item once the current one has been transferred
  always @(negedge clk) begin : driver
    rx_item_t item;
    if (rst_n && items_accepted == items_sent) begin
      if (drive_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        item = drive_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= item.cmd;
        in_tdata <= item.rx;
        items_sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic offer(input logic [1:0] cmd, input logic [7:0] rx);
    rx_item_t it;
    it.cmd = cmd;
    it.rx = rx;
    drive_q.push_back(it);
  endtask

  task automatic queue_reply(input reply_kind_t kind);
    logic [7:0] r [10];
    logic [15:0] sum;
    int i;
    int spot;
    int tick_at;
    r[0] = SYNC1;
    r[1] = SYNC2;
    r[2] = ACK_CLASS;
    r[3] = (kind == RPL_NAK) ? NAK_ID : ACK_ID;
    r[4] = ACK_LEN;
    r[5] = $urandom_range(1, 0) ? 8'($urandom) : 8'h00;
    r[6] = CFG_CLASS;
    r[7] = TP5_ID;
    sum = reply_sum({r[7], r[6], r[5], r[4], r[3], r[2]});
    r[8] = sum[7:0];
    r[9] = sum[15:8];
    if (kind == RPL_BAD) begin
      spot = $urandom_range(9, 3);
      r[spot] = r[spot] ^ 8'($urandom_range(255, 1));
    end
    if ($urandom_range(4, 0) == 0) offer(CMD_RXBYTE, 8'($urandom));
    tick_at = $urandom_range(15, 0);
    for (i = 0; i < ((kind == RPL_NAK) ? 4 : 10); i++) begin
      if (i == tick_at) offer(CMD_TICK, 8'($urandom));
      offer(CMD_RXBYTE, r[i]);
    end
  endtask

  task automatic queue_burst;
    int pick;
    int n;
    pick = $urandom_range(99, 0);
    if (pick < 6 || (!awaiting_reply && pick < 70)) begin
      offer(CMD_START, 8'($urandom));
    end else if (pick < 46) begin
      queue_reply(RPL_ACK);
    end else if (pick < 60) begin
      queue_reply(RPL_NAK);
    end else if (pick < 74) begin
      queue_reply(RPL_BAD);
    end else if (pick < 86) begin
      n = (tmo_cfg > 16'd8) ? $urandom_range(4, 1) : int'(tmo_cfg) + 1 + $urandom_range(1, 0);
      repeat (n) offer(CMD_TICK, 8'($urandom));
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) offer(2'($urandom_range(3, 1)), 8'($urandom));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FREQ:    hz_cfg = value;
      REG_TIMEOUT: tmo_cfg = value[15:0];
      REG_NEEDED:  need_cfg = value[3:0];
      default:     maxatt_cfg = value[3:0];
    endcase
  endtask

  task automatic write_settings(input logic [31:0] hz, input logic [15:0] tmo,
                                input logic [3:0] need, input logic [3:0] maxatt);
    write_reg(REG_FREQ, hz);
    write_reg(REG_TIMEOUT, {16'h0, tmo});
    write_reg(REG_NEEDED, {28'h0, need});
    write_reg(REG_MAXATT, {28'h0, maxatt});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every queued item went out and every predicted result came back
  task automatic settle;
    @(negedge clk);
    while (drive_q.size() != 0 || items_accepted != items_sent || frame_status_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int target, input int hold_at, input int pause_at);
    while (live_items < target) begin
      @(posedge clk);
      if (drive_q.size() < 2) queue_burst;
      if (hold_at > 0 && live_items >= hold_at) begin
        holds_asked++;
        hold_at = 0;
      end
      if (pause_at > 0 && live_items >= pause_at) begin
        settle;
        pause_at = 0;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 33;
    recv_idle_pct = 81;

    offer(CMD_TICK, 8'h00);
    offer(CMD_RXBYTE, 8'hFF);
    offer(CMD_UNUSED, 8'h5A);
    offer(CMD_START, 8'h00);
    queue_reply(RPL_ACK);
    settle;
    write_settings(32'hFFFF_FFFF, 16'd1, 4'd1, 4'd2);
    offer(CMD_START, 8'hFF);
    offer(CMD_TICK, 8'h00);
    offer(CMD_TICK, 8'hFF);
    queue_reply(RPL_NAK);
    settle;
    write_settings(32'h0, 16'hFFFF, 4'd0, 4'd15);
    offer(CMD_START, 8'h00);
    settle;
    write_settings($urandom, 16'd3, 4'd1, 4'd0);
    offer(CMD_START, 8'h00);
    settle;

    write_settings($urandom, 16'd3, 4'd3, 4'd10);
    run_phase(180, 80, 0);
    settle;
    send_idle_pct = 81;
    recv_idle_pct = 33;
    write_settings(32'h8000_0001, 16'hFFFF, 4'd15, 4'd15);
    run_phase(340, 0, 260);
    settle;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings($urandom, 16'($urandom_range(4, 1)), 4'($urandom_range(2, 1)), 4'd1);
    run_phase(500, 0, 0);
    settle;

    $display("Covered %0d input transfers (%0d acted on) and %0d result transfers",
             items_accepted, live_items, results_seen);
    $display("Attempts: ack %0d, nak %0d, bad reply %0d, timeout %0d; sequences ok %0d, failed %0d",
             outcome_tally[OC_ACK], outcome_tally[OC_NAK], outcome_tally[OC_FAIL],
             outcome_tally[OC_TIMEOUT], finals_ok, finals_failed);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/utp_pkg.sv
design/utp_dp.sv
design/utp_ctrl.sv
design/ubx_timepulse_config_with_ack.sv
test/tb_ubx_timepulse_config_with_ack.sv
